// ===== hdl/eatm_pkg.sv =====
// Shared types and constants for the event action table matcher.
// Used by eatm_table_ram and event_action_table_matcher_core; no dependencies.
`timescale 1ns / 1ps

package eatm_pkg;

   localparam int ENTRIES      = 32;
   localparam int PINS         = 32;
   localparam int IDX_W        = $clog2(ENTRIES);
   localparam int CNT_W        = IDX_W + 1;
   localparam int PIN_W        = 5;
   localparam int ACTIVE_W     = 6;
   localparam int TICKS_W      = 16;
   localparam int MAX_SCAN     = 32;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_EVENT   = 2'd1,
      OP_RESTORE = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      MODE_OFF    = 2'd0,
      MODE_ON     = 2'd1,
      MODE_TOGGLE = 2'd2,
      MODE_PULSE  = 2'd3
   } mode_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   // One table slot, 28 bits.
   typedef struct packed {
      logic [7:0]       node;
      logic [7:0]       mask;
      logic [PIN_W-1:0] pin;
      logic [3:0]       duration;
      logic [1:0]       mode;
      logic             dflt;
   } slot_type;

   // Port bundle between the core and the table memory.
   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      slot_type         wr_data;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
   } ram_req_type;

endpackage

// ===== hdl/eatm_table_ram.sv =====
// Action table storage: one write port, one registered read port.
// Depends on eatm_pkg for the slot layout and depth.
`timescale 1ns / 1ps

module eatm_table_ram (
   input  logic                 clock,
   input  eatm_pkg::ram_req_type ram_req,
   output eatm_pkg::slot_type   rd_data
);
   import eatm_pkg::*;

   slot_type mem [ENTRIES];
   slot_type rd_data_ff;

   // Write the slot on a load.
   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   // Read one slot, data valid the next cycle; hold when not enabled.
   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/event_action_table_matcher_core.sv =====
// Event action table matcher: scans the action table for each event and issues
// pin commands. An event holds off the next request until its scan of n slots ends,
// n being active_entries saturated at 32, and longer on output stalls: the single table
// read port gives one slot a cycle unless the held command cannot move on. A command
// leaves once the next match is found, the last when the scan ends. Synchronous
// active-high reset clears mirror, scan length and control.
`timescale 1ns / 1ps

module event_action_table_matcher_core (
   input  logic                          clock,
   input  logic                          reset,
   // configuration
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [eatm_pkg::ACTIVE_W-1:0] csr_wdata,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_opcode,
   input  logic [4:0]                    req_entry_index,
   input  logic [7:0]                    req_entry_node,
   input  logic [7:0]                    req_entry_mask,
   input  logic [4:0]                    req_entry_pin,
   input  logic [3:0]                    req_entry_duration,
   input  logic [1:0]                    req_entry_mode,
   input  logic                          req_entry_default,
   input  logic [7:0]                    req_event_node,
   input  logic [7:0]                    req_event_flags,
   input  logic [4:0]                    req_restore_pin,
   input  logic                          req_restore_level,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [4:0]                    rsp_cmd_pin,
   output logic                          rsp_cmd_level,
   output logic [15:0]                   rsp_pulse_ticks,
   output logic                          rsp_restore_to,
   output logic                          rsp_last_cmd
);
   import eatm_pkg::*;

   state_type             state_ff, state_in;
   logic [ACTIVE_W-1:0]   active_ff;
   logic [CNT_W-1:0]      scan_lim_ff, scan_lim_in;
   logic [CNT_W-1:0]      scan_idx_ff, scan_idx_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [7:0]            ev_node_ff, ev_node_in;
   logic [7:0]            ev_flags_ff, ev_flags_in;
   logic [PINS-1:0]       levels_ff, levels_in;

   // held command, waiting to learn whether it is the last one
   logic                  pend_vld_ff, pend_vld_in;
   logic [PIN_W-1:0]      pend_pin_ff, pend_pin_in;
   logic                  pend_lvl_ff, pend_lvl_in;
   logic [TICKS_W-1:0]    pend_ticks_ff, pend_ticks_in;
   logic                  pend_rest_ff, pend_rest_in;

   // output register
   logic                  out_vld_ff, out_vld_in;
   logic [PIN_W-1:0]      out_pin_ff, out_pin_in;
   logic                  out_lvl_ff, out_lvl_in;
   logic [TICKS_W-1:0]    out_ticks_ff, out_ticks_in;
   logic                  out_rest_ff, out_rest_in;
   logic                  out_last_ff, out_last_in;

   ram_req_type           ram_req;
   slot_type              slot;

   logic                  req_fire;
   logic                  out_free;
   logic                  eval_match;
   logic                  scan_end;
   logic                  stall;
   logic                  finish;
   logic [CNT_W-1:0]      lim_now;
   logic                  new_lvl;
   logic [TICKS_W-1:0]    new_ticks;
   logic                  new_rest;

   eatm_table_ram u_table (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (slot)
   );

   assign req_fire = req_valid && req_ready;
   assign out_free = !out_vld_ff || rsp_ready;
   assign csr_ready = 1'b1;

   // Saturate the scan length at the table depth.
   always_comb begin
      if (active_ff > ACTIVE_W'(MAX_SCAN)) begin
         lim_now = CNT_W'(MAX_SCAN);
      end else begin
         lim_now = CNT_W'(active_ff);
      end
   end

   // Match and command of the slot now under evaluation.
   assign eval_match = rd_vld_ff && (slot.node == ev_node_ff)
                       && ((slot.mask & ev_flags_ff) != 8'd0);
   assign scan_end   = (state_ff == ST_SCAN) && !rd_vld_ff
                       && (scan_idx_ff == scan_lim_ff);
   assign stall      = eval_match && pend_vld_ff && !out_free;
   assign finish     = scan_end && (!pend_vld_ff || out_free);

   always_comb begin
      new_ticks = '0;
      new_rest  = 1'b0;
      unique case (mode_type'(slot.mode))
         MODE_OFF:    new_lvl = 1'b0;
         MODE_ON:     new_lvl = 1'b1;
         MODE_TOGGLE: new_lvl = !levels_ff[slot.pin];
         default: begin
            new_lvl   = !slot.dflt;
            new_ticks = (TICKS_W'(1) << slot.duration) + TICKS_W'(1);
            new_rest  = slot.dflt;
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (opcode_type'(req_opcode) == OP_EVENT)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // State outputs.
   always_comb begin
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_SCAN: req_ready = 1'b0;
      endcase
   end

   // Datapath: request decode, table scan, command hand-off.
   always_comb begin
      scan_lim_in   = scan_lim_ff;
      scan_idx_in   = scan_idx_ff;
      rd_vld_in     = rd_vld_ff;
      ev_node_in    = ev_node_ff;
      ev_flags_in   = ev_flags_ff;
      levels_in     = levels_ff;
      pend_vld_in   = pend_vld_ff;
      pend_pin_in   = pend_pin_ff;
      pend_lvl_in   = pend_lvl_ff;
      pend_ticks_in = pend_ticks_ff;
      pend_rest_in  = pend_rest_ff;
      out_vld_in    = out_vld_ff && !rsp_ready;
      out_pin_in    = out_pin_ff;
      out_lvl_in    = out_lvl_ff;
      out_ticks_in  = out_ticks_ff;
      out_rest_in   = out_rest_ff;
      out_last_in   = out_last_ff;
      ram_req.wr_en   = 1'b0;
      ram_req.wr_addr = req_entry_index;
      ram_req.wr_data = '{node: req_entry_node, mask: req_entry_mask,
                          pin: req_entry_pin, duration: req_entry_duration,
                          mode: req_entry_mode, dflt: req_entry_default};
      ram_req.rd_en   = 1'b0;
      ram_req.rd_addr = scan_idx_ff[IDX_W-1:0];

      // Decode an accepted request.
      if (req_fire) begin
         unique case (opcode_type'(req_opcode))
            OP_LOAD: begin
               ram_req.wr_en = 1'b1;
               levels_in[req_entry_pin] = req_entry_default;
            end
            OP_RESTORE: begin
               levels_in[req_restore_pin] = req_restore_level;
            end
            OP_EVENT: begin
               ev_node_in  = req_event_node;
               ev_flags_in = req_event_flags;
               scan_lim_in = lim_now;
               scan_idx_in = '0;
               rd_vld_in   = 1'b0;
               pend_vld_in = 1'b0;
            end
            default: ;
         endcase
      end

      // Advance the scan one slot unless the held command cannot move on.
      if ((state_ff == ST_SCAN) && !stall) begin
         if (scan_idx_ff != scan_lim_ff) begin
            ram_req.rd_en = 1'b1;
            rd_vld_in     = 1'b1;
            scan_idx_in   = scan_idx_ff + CNT_W'(1);
         end else begin
            rd_vld_in = 1'b0;
         end
         if (eval_match) begin
            levels_in[slot.pin] = new_lvl;
            if (pend_vld_ff) begin
               out_vld_in   = 1'b1;
               out_pin_in   = pend_pin_ff;
               out_lvl_in   = pend_lvl_ff;
               out_ticks_in = pend_ticks_ff;
               out_rest_in  = pend_rest_ff;
               out_last_in  = 1'b0;
            end
            pend_vld_in   = 1'b1;
            pend_pin_in   = slot.pin;
            pend_lvl_in   = new_lvl;
            pend_ticks_in = new_ticks;
            pend_rest_in  = new_rest;
         end
      end

      // Flush the held command as the final one of the event.
      if (finish && pend_vld_ff) begin
         out_vld_in   = 1'b1;
         out_pin_in   = pend_pin_ff;
         out_lvl_in   = pend_lvl_ff;
         out_ticks_in = pend_ticks_ff;
         out_rest_in  = pend_rest_ff;
         out_last_in  = 1'b1;
         pend_vld_in  = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         active_ff   <= '0;
         levels_ff   <= '0;
         rd_vld_ff   <= 1'b0;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
         scan_idx_ff <= '0;
         scan_lim_ff <= '0;
      end else begin
         state_ff    <= state_in;
         levels_ff   <= levels_in;
         rd_vld_ff   <= rd_vld_in;
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
         scan_idx_ff <= scan_idx_in;
         scan_lim_ff <= scan_lim_in;
         if (csr_valid && csr_ready) begin
            active_ff <= csr_wdata;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ev_node_ff    <= ev_node_in;
      ev_flags_ff   <= ev_flags_in;
      pend_pin_ff   <= pend_pin_in;
      pend_lvl_ff   <= pend_lvl_in;
      pend_ticks_ff <= pend_ticks_in;
      pend_rest_ff  <= pend_rest_in;
      out_pin_ff    <= out_pin_in;
      out_lvl_ff    <= out_lvl_in;
      out_ticks_ff  <= out_ticks_in;
      out_rest_ff   <= out_rest_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_cmd_pin     = out_pin_ff;
   assign rsp_cmd_level   = out_lvl_ff;
   assign rsp_pulse_ticks = out_ticks_ff;
   assign rsp_restore_to  = out_rest_ff;
   assign rsp_last_cmd    = out_last_ff;

endmodule

// ===== dv/event_action_table_matcher_core_test.sv =====
// Self-checking testbench for event_action_table_matcher_core: drives table loads,
// events and restore reports, predicts every pin command and checks each one.
// Depends on eatm_pkg and the core RTL only.
`timescale 1ns / 1ps

module event_action_table_matcher_core_test;

   import eatm_pkg::*;

   localparam logic [1:0]  OP_UNUSED     = 2'd3;
   localparam int          SETTLE_CYCLES = 40;
   localparam int          LONG_HOLD     = 400;
   localparam int          CYCLE_LIMIT   = 400000;
   localparam int          MAX_REPORTS   = 10;
   // node ids that random loads and events favor, so that events hit the table
   localparam logic [31:0] NODE_POOL     = 32'hFFA55A00;

   typedef struct packed {
      logic [1:0] opcode;
      logic [4:0] entry_index;
      logic [7:0] entry_node;
      logic [7:0] entry_mask;
      logic [4:0] entry_pin;
      logic [3:0] entry_duration;
      logic [1:0] entry_mode;
      logic       entry_default;
      logic [7:0] event_node;
      logic [7:0] event_flags;
      logic [4:0] restore_pin;
      logic       restore_level;
   } request_t;

   typedef struct packed {
      logic [4:0]  pin;
      logic        level;
      logic [15:0] ticks;
      logic        restore_to;
      logic        last_cmd;
   } pin_command_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [ACTIVE_W-1:0] csr_wdata = '0;
   logic                req_valid = 1'b0;
   logic                req_ready;
   request_t            offered_request = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [4:0]          rsp_cmd_pin;
   logic                rsp_cmd_level;
   logic [15:0]         rsp_pulse_ticks;
   logic                rsp_restore_to;
   logic                rsp_last_cmd;

   // predictor state
   slot_type            action_slots [ENTRIES];
   logic [PINS-1:0]     mirrored_levels = '0;
   logic [ACTIVE_W-1:0] scan_length = '0;

   request_t            pending_requests [$];
   pin_command_t        expected_commands [$];

   int                  requests_queued = 0;
   int                  requests_accepted = 0;
   int                  commands_checked = 0;
   int                  settings_applied = 0;
   int                  failures = 0;
   int                  cycle_count = 0;
   int                  burst_left = 0;
   int                  gap_left = 0;
   int                  holds_requested = 0;
   int                  holds_started = 0;
   int                  hold_left = 0;
   int                  window_left = 0;
   int                  stall_mode = 0;

   event_action_table_matcher_core DUT (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (offered_request.opcode),
      .req_entry_index    (offered_request.entry_index),
      .req_entry_node     (offered_request.entry_node),
      .req_entry_mask     (offered_request.entry_mask),
      .req_entry_pin      (offered_request.entry_pin),
      .req_entry_duration (offered_request.entry_duration),
      .req_entry_mode     (offered_request.entry_mode),
      .req_entry_default  (offered_request.entry_default),
      .req_event_node     (offered_request.event_node),
      .req_event_flags    (offered_request.event_flags),
      .req_restore_pin    (offered_request.restore_pin),
      .req_restore_level  (offered_request.restore_level),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_cmd_pin        (rsp_cmd_pin),
      .rsp_cmd_level      (rsp_cmd_level),
      .rsp_pulse_ticks    (rsp_pulse_ticks),
      .rsp_restore_to     (rsp_restore_to),
      .rsp_last_cmd       (rsp_last_cmd)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic note_failure(input string msg);
      failures++;
      if (failures <= MAX_REPORTS) begin
         $display("ERROR at %0t: %s", $realtime, msg);
      end
   endtask

   // Update the table and mirror for one accepted request and queue the commands it gives
   task automatic predict_pin_commands(input request_t r);
      slot_type     s;
      pin_command_t cmd;
      pin_command_t held;
      bit           have_held;
      int           n;
      logic         lvl;
      have_held = 1'b0;
      held = '0;
      case (r.opcode)
         OP_LOAD: begin
            s.node     = r.entry_node;
            s.mask     = r.entry_mask;
            s.pin      = r.entry_pin;
            s.duration = r.entry_duration;
            s.mode     = r.entry_mode;
            s.dflt     = r.entry_default;
            action_slots[r.entry_index] = s;
            mirrored_levels[r.entry_pin] = r.entry_default;
         end
         OP_RESTORE: begin
            mirrored_levels[r.restore_pin] = r.restore_level;
         end
         OP_EVENT: begin
            // saturate the scan at the table size
            n = scan_length;
            if (n > ENTRIES) n = ENTRIES;
            if (n > MAX_SCAN) n = MAX_SCAN;
            for (int i = 0; i < n; i++) begin
               s = action_slots[i];
               if (s.node == r.event_node && (s.mask & r.event_flags) != 8'd0) begin
                  cmd = '0;
                  cmd.pin = s.pin;
                  case (s.mode)
                     MODE_OFF:    lvl = 1'b0;
                     MODE_ON:     lvl = 1'b1;
                     MODE_TOGGLE: lvl = ~mirrored_levels[s.pin];
                     default: begin
                        lvl = ~s.dflt;
                        cmd.ticks = (16'd1 << s.duration) + 16'd1;
                        cmd.restore_to = s.dflt;
                     end
                  endcase
                  mirrored_levels[s.pin] = lvl;
                  cmd.level = lvl;
                  // hold each command back one match so the final one can be marked
                  if (have_held) expected_commands.push_back(held);
                  held = cmd;
                  have_held = 1'b1;
               end
            end
            if (have_held) begin
               held.last_cmd = 1'b1;
               expected_commands.push_back(held);
            end
         end
         default: ;
      endcase
   endtask

   // Request driver: bursts of random length with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_pin_commands(offered_request);
            requests_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               offered_request <= pending_requests.pop_front();
               req_valid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 10);
                  gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Command receiver: stall windows of varying shape, plus long hold-offs on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_started != holds_requested) begin
         holds_started <= holds_started + 1;
         hold_left <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else begin
         if (window_left == 0) begin
            window_left <= $urandom_range(16, 64);
            stall_mode <= $urandom_range(0, 2);
         end else begin
            window_left <= window_left - 1;
         end
         case (stall_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= (window_left[1:0] == 2'd0);
         endcase
      end
   end

   // Command monitor: compare each accepted command with the oldest prediction
   always @(posedge clock) begin
      pin_command_t got;
      pin_command_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.pin        = rsp_cmd_pin;
         got.level      = rsp_cmd_level;
         got.ticks      = rsp_pulse_ticks;
         got.restore_to = rsp_restore_to;
         got.last_cmd   = rsp_last_cmd;
         if (expected_commands.size() == 0) begin
            note_failure($sformatf("unexpected command pin %0d level %0b ticks %0d",
                                   got.pin, got.level, got.ticks));
         end else begin
            want = expected_commands.pop_front();
            commands_checked++;
            if (got.pin !== want.pin || got.level !== want.level ||
                got.ticks !== want.ticks || got.restore_to !== want.restore_to ||
                got.last_cmd !== want.last_cmd) begin
               note_failure({
                  $sformatf("expected pin %0d level %0b ticks %0d restore %0b last %0b",
                            want.pin, want.level, want.ticks, want.restore_to,
                            want.last_cmd),
                  $sformatf(", got pin %0d level %0b ticks %0d restore %0b last %0b",
                            got.pin, got.level, got.ticks, got.restore_to,
                            got.last_cmd)});
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic queue_request(input request_t r);
      pending_requests.push_back(r);
      requests_queued++;
   endtask

   function automatic request_t random_fields();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[$bits(request_t)-1:0];
   endfunction

   task automatic queue_load(input int idx, input logic [7:0] node, input logic [7:0] mask,
                             input int pin, input int dur, input mode_type mode,
                             input logic dflt);
      request_t r;
      r = random_fields();
      r.opcode         = OP_LOAD;
      r.entry_index    = 5'(idx);
      r.entry_node     = node;
      r.entry_mask     = mask;
      r.entry_pin      = 5'(pin);
      r.entry_duration = 4'(dur);
      r.entry_mode     = mode;
      r.entry_default  = dflt;
      queue_request(r);
   endtask

   task automatic queue_event(input logic [7:0] node, input logic [7:0] flags);
      request_t r;
      r = random_fields();
      r.opcode      = OP_EVENT;
      r.event_node  = node;
      r.event_flags = flags;
      queue_request(r);
   endtask

   task automatic queue_restore(input int pin, input logic lvl);
      request_t r;
      r = random_fields();
      r.opcode        = OP_RESTORE;
      r.restore_pin   = 5'(pin);
      r.restore_level = lvl;
      queue_request(r);
   endtask

   // Mostly events and loads aimed at a few shared node ids, some restores and noise
   task automatic queue_random(input int count);
      request_t r;
      int       pick;
      for (int k = 0; k < count; k++) begin
         r = random_fields();
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            r.opcode = OP_LOAD;
            if ($urandom_range(0, 4) != 0) r.entry_node = NODE_POOL[8*$urandom_range(0, 3) +: 8];
            if ($urandom_range(0, 1) != 0) r.entry_pin = 5'($urandom_range(0, 7));
         end else if (pick < 78) begin
            r.opcode = OP_EVENT;
            if ($urandom_range(0, 6) != 0) r.event_node = NODE_POOL[8*$urandom_range(0, 3) +: 8];
         end else if (pick < 94) begin
            r.opcode = OP_RESTORE;
            if ($urandom_range(0, 1) != 0) r.restore_pin = 5'($urandom_range(0, 7));
         end else begin
            r.opcode = OP_UNUSED;
         end
         queue_request(r);
      end
   endtask

   // Wait for every request to be taken and every command to arrive, then let scans finish
   task automatic wait_idle();
      do @(posedge clock);
      while (requests_accepted != requests_queued || expected_commands.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_scan_length(input logic [ACTIVE_W-1:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      scan_length = value;
      settings_applied++;
   endtask

   initial begin
      request_t r;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // scan length zero after reset: events give nothing
      queue_event(8'h00, 8'hFF);
      r = random_fields();
      r.opcode = OP_UNUSED;
      queue_request(r);
      queue_restore(31, 1'b1);
      queue_load(0, 8'h00, 8'hFF, 0, 0, MODE_OFF, 1'b1);
      queue_load(1, 8'h00, 8'h01, 31, 15, MODE_PULSE, 1'b0);
      queue_load(2, 8'h00, 8'h80, 5, 0, MODE_PULSE, 1'b1);
      queue_load(3, 8'h00, 8'hFF, 5, 7, MODE_TOGGLE, 1'b0);
      queue_load(4, 8'hFF, 8'hFF, 31, 3, MODE_ON, 1'b0);
      queue_load(5, 8'hFF, 8'h00, 7, 2, MODE_ON, 1'b0);
      queue_load(6, 8'hFF, 8'h0F, 7, 9, MODE_TOGGLE, 1'b1);
      queue_load(7, 8'h3C, 8'hFF, 16, 4, MODE_TOGGLE, 1'b0);

      // directed events over the first eight slots
      write_scan_length(6'd8);
      queue_event(8'h00, 8'hFF);
      queue_event(8'h00, 8'h01);
      queue_event(8'hFF, 8'hF0);
      queue_event(8'hFF, 8'h0F);
      queue_event(8'h55, 8'hFF);
      queue_event(8'h3C, 8'h00);
      queue_restore(16, 1'b1);
      queue_event(8'h3C, 8'h01);
      queue_event(8'h3C, 8'h80);
      queue_load(7, 8'h3C, 8'hFF, 16, 4, MODE_TOGGLE, 1'b0);
      queue_event(8'h3C, 8'h10);

      // fill the rest of the table before any longer scan
      for (int i = 8; i < ENTRIES; i++) begin
         r = random_fields();
         r.opcode = OP_LOAD;
         r.entry_index = 5'(i);
         r.entry_node = NODE_POOL[8*$urandom_range(0, 3) +: 8];
         queue_request(r);
      end

      write_scan_length(6'd32);
      queue_random(10);

      // saturated scan length with a long receiver hold-off to back up the input
      write_scan_length(6'd63);
      holds_requested <= holds_requested + 1;
      queue_random(16);

      write_scan_length(6'd1);
      queue_random(6);

      write_scan_length(6'd0);
      queue_random(4);

      write_scan_length(6'($urandom_range(2, 31)));
      queue_random(10);

      write_scan_length(6'd32);
      queue_random(8);

      wait_idle();
      $display("Checked %0d pin commands from %0d requests", commands_checked, requests_accepted);
      $display("over %0d scan-length settings, from empty to saturated", settings_applied);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
